/* design/assert_macros.svh */
// Assertion macros for the union-find design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define UFS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define UFS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/ufs_pkg.sv */
// Package: widths, payload structs, sequencer states and shared-unit opcodes.
package ufs_pkg;

   localparam int IDX_W       = 10;
   localparam int SIZE_W      = 11;
   localparam int TABLE_DEPTH = 1 << IDX_W;

   typedef struct packed {
      logic [IDX_W-1:0] first_element;
      logic [IDX_W-1:0] second_element;
   } req_payload_type;

   typedef struct packed {
      logic [IDX_W-1:0]  set_root;
      logic [SIZE_W-1:0] set_size;
      logic              did_merge;
      logic              index_error;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RANGE_A,
      ST_RANGE_B,
      ST_FIND_RD,
      ST_FIND_CHK,
      ST_COMP_RD,
      ST_COMP_WR,
      ST_ROOT_EQ,
      ST_SAME_SZ,
      ST_SZ_A,
      ST_SZ_B,
      ST_MERGE,
      ST_ZERO
   } ufs_state_type;

   typedef enum logic [1:0] {
      OP_EQ,
      OP_GE,
      OP_GT,
      OP_ADD
   } ufs_op_type;

   typedef struct packed {
      ufs_op_type        op;
      logic [SIZE_W-1:0] lhs;
      logic [SIZE_W-1:0] rhs;
   } alu_req_type;

   typedef struct packed {
      logic              flag;
      logic [SIZE_W-1:0] sum;
   } alu_rsp_type;

endpackage

/* design/ufs_alu.sv */
// Shared compare/add unit used by the compare and add steps of the union-find sequencer.
module ufs_alu import ufs_pkg::*; (
   input  alu_req_type alu_req,
   output alu_rsp_type alu_rsp
);

   always_comb begin
      alu_rsp.sum  = alu_req.lhs + alu_req.rhs;
      case (alu_req.op)
         OP_EQ:   alu_rsp.flag = (alu_req.lhs == alu_req.rhs);
         OP_GE:   alu_rsp.flag = (alu_req.lhs >= alu_req.rhs);
         OP_GT:   alu_rsp.flag = (alu_req.lhs >  alu_req.rhs);
         OP_ADD:  alu_rsp.flag = 1'b0;
         default: alu_rsp.flag = 1'b0;
      endcase
   end

endmodule

/* design/union_find_by_size_core.sv */
// Top level: union-find by size with path compression over single-port tables.
//
//  channel   | direction | handshake           | payload
//  ----------+-----------+---------------------+----------------------------
//  req_      | in        | req_valid/req_ready | req_payload (two indices)
//  rsp_      | out       | rsp_valid/rsp_ready | rsp_payload (root, size, flags)
//  csr_      | in        | csr_wr_en           | csr_wr_data (element_count)
//
//  One item at a time: each element is walked to its root, the path is
//  compressed, the roots are compared and, if they differ, merged by size;
//  an index error ends the item at its range check.
//  The walk is paced by the single-port parent table: one hop per cycle while
//  finding, then a read and a write per visited node while compressing.
//  Reset: a clearing pass over all 1024 entries rewrites both tables;
//  req_ready stays low meanwhile, csr writes are taken as ever.
//  Stalls: a finished result waits in the rsp register; the next item is taken
//  meanwhile and holds in its last step only if its result would overwrite it.
`include "assert_macros.svh"

module union_find_by_size_core import ufs_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload,
   input  logic            csr_wr_en,
   input  logic [SIZE_W-1:0] csr_wr_data
);

   // Sequencer state and control registers.
   ufs_state_type state_ff, state_in;
   logic [IDX_W-1:0]  clr_ff, clr_in;
   logic              phase_ff, phase_in;      // 0: working on first, 1: second
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SIZE_W-1:0] count_ff;

   // Datapath registers (no reset needed).
   logic [IDX_W-1:0]  a_ff, a_in;
   logic [IDX_W-1:0]  b_ff, b_in;
   logic [IDX_W-1:0]  cur_ff, cur_in;          // walk pointer; holds the root when found
   logic [IDX_W-1:0]  walk_ff, walk_in;        // compression pointer
   logic [IDX_W-1:0]  ra_ff, ra_in;
   logic [IDX_W-1:0]  rb_ff, rb_in;
   logic [SIZE_W-1:0] sa_ff, sa_in;
   logic [SIZE_W-1:0] sb_ff, sb_in;
   logic              a_wins_ff, a_wins_in;
   rsp_payload_type   rsp_ff, rsp_in;

   // Tables: parent and size, one port each.
   logic [IDX_W-1:0]  parent_mem_ff [TABLE_DEPTH];
   logic [SIZE_W-1:0] size_mem_ff   [TABLE_DEPTH];
   logic [IDX_W-1:0]  par_rdata_ff;
   logic [SIZE_W-1:0] size_rdata_ff;

   logic              par_we, par_re;
   logic [IDX_W-1:0]  par_addr, par_wdata;
   logic              size_we, size_re;
   logic [IDX_W-1:0]  size_addr;
   logic [SIZE_W-1:0] size_wdata;

   alu_req_type       alu_req;
   alu_rsp_type       alu_rsp;

   logic              rsp_free;
   logic              accept;
   logic              rsp_load;
   logic [IDX_W-1:0]  win_idx, lose_idx;

   ufs_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign accept   = req_valid && req_ready;
   assign win_idx  = a_wins_ff ? ra_ff : rb_ff;
   assign lose_idx = a_wins_ff ? rb_ff : ra_ff;

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:    if (clr_ff == {IDX_W{1'b1}}) state_in = ST_IDLE;
         ST_IDLE:     if (req_valid) state_in = ST_RANGE_A;
         ST_RANGE_A: begin
            if (!alu_rsp.flag) state_in = ST_RANGE_B;
            else if (rsp_free) state_in = ST_IDLE;
         end
         ST_RANGE_B: begin
            if (!alu_rsp.flag) state_in = ST_FIND_RD;
            else if (rsp_free) state_in = ST_IDLE;
         end
         ST_FIND_RD:  state_in = ST_FIND_CHK;
         ST_FIND_CHK: if (alu_rsp.flag) state_in = ST_COMP_RD;
         ST_COMP_RD: begin
            if (!alu_rsp.flag) state_in = ST_COMP_WR;
            else if (phase_ff) state_in = ST_ROOT_EQ;
            else state_in = ST_FIND_RD;
         end
         ST_COMP_WR:  state_in = ST_COMP_RD;
         ST_ROOT_EQ:  state_in = alu_rsp.flag ? ST_SAME_SZ : ST_SZ_A;
         ST_SAME_SZ:  if (rsp_free) state_in = ST_IDLE;
         ST_SZ_A:     state_in = ST_SZ_B;
         ST_SZ_B:     state_in = ST_MERGE;
         ST_MERGE:    if (rsp_free) state_in = ST_ZERO;
         ST_ZERO:     state_in = ST_IDLE;
         default:     state_in = ST_CLEAR;
      endcase
   end

   // Shared-unit operation for each step.
   always_comb begin
      alu_req.op  = OP_EQ;
      alu_req.lhs = '0;
      alu_req.rhs = '0;
      case (state_ff)
         ST_RANGE_A: begin
            alu_req.op  = OP_GE;
            alu_req.lhs = {1'b0, a_ff};
            alu_req.rhs = count_ff;
         end
         ST_RANGE_B: begin
            alu_req.op  = OP_GE;
            alu_req.lhs = {1'b0, b_ff};
            alu_req.rhs = count_ff;
         end
         ST_FIND_CHK: begin
            alu_req.op  = OP_EQ;
            alu_req.lhs = {1'b0, par_rdata_ff};
            alu_req.rhs = {1'b0, cur_ff};
         end
         ST_COMP_RD: begin
            alu_req.op  = OP_EQ;
            alu_req.lhs = {1'b0, walk_ff};
            alu_req.rhs = {1'b0, cur_ff};
         end
         ST_ROOT_EQ: begin
            alu_req.op  = OP_EQ;
            alu_req.lhs = {1'b0, ra_ff};
            alu_req.rhs = {1'b0, rb_ff};
         end
         ST_SZ_B: begin
            alu_req.op  = OP_GT;
            alu_req.lhs = sa_ff;
            alu_req.rhs = size_rdata_ff;
         end
         ST_MERGE: begin
            alu_req.op  = OP_ADD;
            alu_req.lhs = sa_ff;
            alu_req.rhs = sb_ff;
         end
         default: begin
            alu_req.op = OP_EQ;
         end
      endcase
   end

   // Table ports for each step.
   always_comb begin
      par_we     = 1'b0;
      par_re     = 1'b0;
      par_addr   = cur_ff;
      par_wdata  = cur_ff;
      size_we    = 1'b0;
      size_re    = 1'b0;
      size_addr  = ra_ff;
      size_wdata = '0;
      case (state_ff)
         ST_CLEAR: begin
            par_we     = 1'b1;
            par_addr   = clr_ff;
            par_wdata  = clr_ff;
            size_we    = 1'b1;
            size_addr  = clr_ff;
            size_wdata = SIZE_W'(1);
         end
         ST_FIND_RD: begin
            par_re   = 1'b1;
            par_addr = cur_ff;
         end
         ST_FIND_CHK: begin
            // follow the chain: fetch the next parent at once
            par_re      = !alu_rsp.flag;
            par_addr    = par_rdata_ff;
         end
         ST_COMP_RD: begin
            par_re      = !alu_rsp.flag;
            par_addr    = walk_ff;
         end
         ST_COMP_WR: begin
            par_we    = 1'b1;
            par_addr  = walk_ff;
            par_wdata = cur_ff;
         end
         ST_ROOT_EQ: begin
            size_re     = 1'b1;
            size_addr   = ra_ff;
         end
         ST_SZ_A: begin
            size_re   = 1'b1;
            size_addr = rb_ff;
         end
         ST_MERGE: begin
            par_we      = rsp_free;
            par_addr    = lose_idx;
            par_wdata   = win_idx;
            size_we     = rsp_free;
            size_addr   = win_idx;
            size_wdata  = alu_rsp.sum;
         end
         ST_ZERO: begin
            size_we    = 1'b1;
            size_addr  = lose_idx;
            size_wdata = '0;
         end
         default: begin
            par_we = 1'b0;
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      clr_in       = clr_ff;
      phase_in     = phase_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      cur_in       = cur_ff;
      walk_in      = walk_ff;
      ra_in        = ra_ff;
      rb_in        = rb_ff;
      sa_in        = sa_ff;
      sb_in        = sb_ff;
      a_wins_in    = a_wins_ff;
      rsp_in       = rsp_ff;
      rsp_load     = 1'b0;
      case (state_ff)
         ST_CLEAR: clr_in = clr_ff + IDX_W'(1);
         ST_IDLE: begin
            if (accept) begin
               a_in     = req_payload.first_element;
               b_in     = req_payload.second_element;
               phase_in = 1'b0;
            end
         end
         ST_RANGE_A, ST_RANGE_B: begin
            if (alu_rsp.flag) begin
               rsp_load = rsp_free;
               rsp_in   = '{set_root: '0, set_size: '0, did_merge: 1'b0, index_error: 1'b1};
            end else begin
               cur_in = a_ff;
            end
         end
         ST_FIND_CHK: begin
            if (alu_rsp.flag) walk_in = phase_ff ? b_ff : a_ff;
            else cur_in = par_rdata_ff;
         end
         ST_COMP_RD: begin
            if (alu_rsp.flag) begin
               if (phase_ff) begin
                  rb_in = cur_ff;
               end else begin
                  ra_in    = cur_ff;
                  cur_in   = b_ff;
                  phase_in = 1'b1;
               end
            end
         end
         ST_COMP_WR: walk_in = par_rdata_ff;
         ST_SAME_SZ: begin
            rsp_load = rsp_free;
            rsp_in   = '{set_root: ra_ff, set_size: size_rdata_ff, did_merge: 1'b0,
                         index_error: 1'b0};
         end
         ST_SZ_A: sa_in = size_rdata_ff;
         ST_SZ_B: begin
            sb_in     = size_rdata_ff;
            a_wins_in = alu_rsp.flag;   // strict: a tie sends the first root under
         end
         ST_MERGE: begin
            rsp_load = rsp_free;
            rsp_in   = '{set_root: win_idx, set_size: alu_rsp.sum, did_merge: 1'b1,
                         index_error: 1'b0};
         end
         default: begin
            rsp_load = 1'b0;
         end
      endcase
      if (!rsp_load) rsp_in = rsp_ff;
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= SIZE_W'(TABLE_DEPTH);
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) count_ff <= csr_wr_data;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      a_ff      <= a_in;
      b_ff      <= b_in;
      cur_ff    <= cur_in;
      walk_ff   <= walk_in;
      ra_ff     <= ra_in;
      rb_ff     <= rb_in;
      sa_ff     <= sa_in;
      sb_ff     <= sb_in;
      a_wins_ff <= a_wins_in;
      rsp_ff    <= rsp_in;
   end

   // Parent table: one port, registered read.
   always_ff @(posedge clock) begin
      if (par_we) parent_mem_ff[par_addr] <= par_wdata;
      if (par_re) par_rdata_ff <= parent_mem_ff[par_addr];
   end

   // Size table: one port, registered read.
   always_ff @(posedge clock) begin
      if (size_we) size_mem_ff[size_addr] <= size_wdata;
      if (size_re) size_rdata_ff <= size_mem_ff[size_addr];
   end

   // Checks.
   `UFS_ASSERT_IMP(a_err_clean, clock, reset, rsp_valid && rsp_payload.index_error,
      rsp_payload.set_size == '0 && rsp_payload.set_root == '0 && !rsp_payload.did_merge,
      "error result carries data")
   `UFS_ASSERT_IMP(a_root_size, clock, reset, rsp_valid && !rsp_payload.index_error,
      rsp_payload.set_size != '0, "root of a set reports size zero")
   `UFS_ASSERT_IMP(a_merge_size, clock, reset, rsp_valid && rsp_payload.did_merge,
      rsp_payload.set_size >= SIZE_W'(2), "merged set smaller than two")
   `UFS_ASSERT_NXT(a_busy_after_accept, clock, reset, accept, !req_ready,
      "item taken while previous item still in progress")

endmodule
